/* design/tbblc_pkg.sv */
`timescale 1ns / 1ps
// Package for the two-table byte-budget LRU cache engine.
// Types, widths and codes shared by the scan unit, the top level and the testbench; no dependencies.
package tbblc_pkg;

  localparam int ENTRIES = 16;              // slots per table
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int ADDR_W  = SLOT_W + 1;      // table bit above the slot
  localparam int DEPTH   = 2 * ENTRIES;
  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 40;
  localparam int STAMP_W = 48;
  localparam int BYTES_W = 45;

  // request codes
  localparam logic [2:0] F_INS_SNAP = 3'd0;
  localparam logic [2:0] F_INS_DELT = 3'd1;
  localparam logic [2:0] F_GET_SNAP = 3'd2;
  localparam logic [2:0] F_GET_DELT = 3'd3;
  localparam logic [2:0] F_EVC_SNAP = 3'd4;
  localparam logic [2:0] F_EVC_DELT = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_TOOBIG  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // notice kinds
  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef struct packed {
    logic [2:0]        func;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] entry_bytes;
  } cmd_t;

  typedef struct packed {
    logic               notice_kind;
    logic               which_table;
    logic [3:0]         slot;
    logic [KEY_W-1:0]   entry_key;
    logic [1:0]         status;
    logic [BYTES_W-1:0] bytes_in_use;
    logic               last;
  } result_t;

  // one stored entry, as held in the tag memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // sequencer to scan unit
  typedef struct packed {
    logic go;       // start a scan
    logic lru;      // 1: min-stamp search over both tables, 0: key search
    logic tbl;      // table for a key search
  } scan_ctl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic              done;
    logic              found;
    logic              tbl;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } scan_res_t;

endpackage

/* design/tbblc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbblc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/tbblc_scan.sv */
`timescale 1ns / 1ps
// Scan unit: walks the tag memory one entry a cycle with a shared comparator,
// doing either a key search over one table or a least-stamp search over both.
// Depends on tbblc_pkg.
module tbblc_scan import tbblc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scan_ctl_t         ctl,
  input  logic [KEY_W-1:0]  key,
  input  logic [DEPTH-1:0]  valid,
  input  entry_t            rd_entry,
  output logic [ADDR_W-1:0] raddr,
  output scan_res_t         res
);

  logic [ADDR_W:0]   cnt;    // next address to issue, can reach DEPTH
  logic [ADDR_W:0]   lim;
  logic              running;
  logic              dv;     // read data valid this cycle
  logic [ADDR_W-1:0] daddr;
  logic              mode_lru;
  logic [STAMP_W-1:0] best;
  logic              take;

  assign raddr = cnt[ADDR_W-1:0];

  // shared compare: key match, or strictly older stamp
  always_comb begin
    take = 1'b0;
    if (dv && valid[daddr]) begin
      if (mode_lru) begin
        take = !res.found || (rd_entry.stamp < best);
      end else begin
        take = !res.found && (rd_entry.key == key);
      end
    end
  end

  // address walk and running best
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      dv        <= 1'b0;
      res.done  <= 1'b0;
      res.found <= 1'b0;
      cnt       <= '0;
      lim       <= '0;
    end else begin
      res.done <= 1'b0;
      if (ctl.go) begin
        running   <= 1'b1;
        dv        <= 1'b0;
        res.found <= 1'b0;
        mode_lru  <= ctl.lru;
        if (ctl.lru) begin
          cnt <= '0;
          lim <= (ADDR_W+1)'(DEPTH);
        end else begin
          cnt <= {1'b0, ctl.tbl, {SLOT_W{1'b0}}};
          lim <= (ADDR_W+1)'({1'b0, ctl.tbl, {SLOT_W{1'b0}}}) + (ADDR_W+1)'(ENTRIES);
        end
      end else if (running) begin
        if (cnt != lim) begin
          dv    <= 1'b1;
          daddr <= cnt[ADDR_W-1:0];
          cnt   <= cnt + 1'b1;
        end else begin
          dv <= 1'b0;
          if (!dv) begin
            running  <= 1'b0;
            res.done <= 1'b1;
          end
        end
        if (take) begin
          res.found <= 1'b1;
          best      <= rd_entry.stamp;
          res.tbl   <= daddr[ADDR_W-1];
          res.slot  <= daddr[SLOT_W-1:0];
          res.key   <= rd_entry.key;
          res.size  <= rd_entry.size;
        end
      end
    end
  end

endmodule

/* design/two_table_byte_budget_lru_cache.sv */
`timescale 1ns / 1ps
// Top level of the two-table byte-budget LRU cache engine: APB register,
// request sequencer, valid bits and counters. Depends on tbblc_pkg,
// tbblc_ram and tbblc_scan.
//
//  channel   | signals                          | transfer
//  ----------+----------------------------------+-------------------------------
//  request   | start, busy, cmd                 | start high while busy low
//  result    | result_valid, result             | one-cycle strobe, no backpressure
//  register  | psel penable pwrite paddr pwdata | APB write, capacity at address 0
//
// A key search walks the 16 entries of one table in the tag memory one per cycle;
// each eviction walks all 32 entries for the oldest stamp. busy stays high until
// the final result is issued. Reset (rst, synchronous) empties both tables and
// clears the byte count and recency clock; capacity returns to 64 MiB. The
// receiver cannot stall.
module two_table_byte_budget_lru_cache import tbblc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        result_valid,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_LRU  = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;

  localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(64'd67108864);

  logic [2:0]          state;
  cmd_t                req;
  logic [SIZE_W-1:0]   capacity;
  logic [BYTES_W-1:0]  bytes_used;
  logic [STAMP_W-1:0]  recency_clock;
  logic [1:0][ENTRIES-1:0] valid;
  logic [SLOT_W-1:0]   slot_r;
  scan_ctl_t           scan_ctl;
  scan_res_t           sres;
  logic [ADDR_W-1:0]   raddr;
  entry_t              rd_entry;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  entry_t              wdata;

  logic                tbl;
  logic [BYTES_W:0]    sum;
  logic [BYTES_W-1:0]  add_sat;
  logic [BYTES_W-1:0]  sub_sat;
  logic                over_budget;
  logic                may_evict;
  logic                free_any;
  logic [SLOT_W-1:0]   free_slot;
  logic [STAMP_W-1:0]  clock_next;

  assign tbl = req.func[0];

  // APB register
  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : {{(64-SIZE_W){1'b0}}, capacity};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      capacity <= pwdata[SIZE_W-1:0];
    end
  end

  // byte arithmetic, saturating both ways
  assign sum         = {1'b0, bytes_used} + (BYTES_W+1)'(req.entry_bytes);
  assign add_sat     = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
  assign sub_sat     = (BYTES_W'(sres.size) > bytes_used) ? '0
                       : bytes_used - BYTES_W'(sres.size);
  assign over_budget = sum > (BYTES_W+1)'(capacity);
  assign may_evict   = tbl ? ((|valid[0]) || (|valid[1])) : (|valid[0]);
  assign clock_next  = (recency_clock == '1) ? recency_clock : recency_clock + 1'b1;

  // first free slot of the target table
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[tbl][i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // tag memory write: insert or stamp refresh
  always_comb begin
    we          = 1'b0;
    waddr       = {tbl, slot_r};
    wdata.key   = req.key;
    wdata.size  = req.entry_bytes;
    wdata.stamp = recency_clock;
    if (state == S_INS) begin
      we = 1'b1;
    end else if (state == S_FIND && sres.done && sres.found
                 && (req.func == F_GET_SNAP || req.func == F_GET_DELT)) begin
      we         = 1'b1;
      waddr      = {tbl, sres.slot};
      wdata.size = sres.size;
    end
  end

  tbblc_ram #(.W(ENTRY_W), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  tbblc_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .key      (req.key),
    .valid    (valid),
    .rd_entry (rd_entry),
    .raddr    (raddr),
    .res      (sres)
  );

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= 1'b0;
      result_valid  <= 1'b0;
      valid         <= '0;
      bytes_used    <= '0;
      recency_clock <= '0;
      scan_ctl      <= '0;
    end else begin
      result_valid <= 1'b0;
      scan_ctl.go  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            req  <= cmd;
            busy <= 1'b1;
            if (cmd.func == F_INS_SNAP || cmd.func == F_INS_DELT) begin
              state <= S_CHK;
            end else if (cmd.func > F_EVC_DELT) begin
              result_valid        <= 1'b1;
              result.notice_kind  <= KIND_FINAL;
              result.which_table  <= 1'b0;
              result.slot         <= '0;
              result.entry_key    <= cmd.key;
              result.status       <= ST_MISS;
              result.bytes_in_use <= bytes_used;
              result.last         <= 1'b1;
              busy                <= 1'b0;
            end else begin
              scan_ctl <= '{go: 1'b1, lru: 1'b0, tbl: cmd.func[0]};
              state    <= S_FIND;
            end
          end
        end
        S_CHK: begin
          if (over_budget && may_evict) begin
            scan_ctl <= '{go: 1'b1, lru: 1'b1, tbl: 1'b0};
            state    <= S_LRU;
          end else if (req.entry_bytes > capacity) begin
            result_valid        <= 1'b1;
            result.notice_kind  <= KIND_FINAL;
            result.which_table  <= tbl;
            result.slot         <= '0;
            result.entry_key    <= req.key;
            result.status       <= ST_TOOBIG;
            result.bytes_in_use <= bytes_used;
            result.last         <= 1'b1;
            busy                <= 1'b0;
            state               <= S_IDLE;
          end else begin
            scan_ctl <= '{go: 1'b1, lru: 1'b0, tbl: tbl};
            state    <= S_FIND;
          end
        end
        S_LRU: begin
          if (sres.done) begin
            // a table was nonempty, so a victim was found
            valid[sres.tbl][sres.slot] <= 1'b0;
            bytes_used          <= sub_sat;
            result_valid        <= 1'b1;
            result.notice_kind  <= KIND_EVICT;
            result.which_table  <= sres.tbl;
            result.slot         <= 4'(sres.slot);
            result.entry_key    <= sres.key;
            result.status       <= ST_OK;
            result.bytes_in_use <= sub_sat;
            result.last         <= 1'b0;
            state               <= S_CHK;
          end
        end
        S_FIND: begin
          if (sres.done) begin
            result.notice_kind <= KIND_FINAL;
            result.which_table <= tbl;
            result.entry_key   <= req.key;
            result.last        <= 1'b1;
            if (req.func == F_INS_SNAP || req.func == F_INS_DELT) begin
              if (sres.found) begin
                bytes_used <= sub_sat;
                slot_r     <= sres.slot;
                state      <= S_INS;
              end else if (free_any) begin
                slot_r <= free_slot;
                state  <= S_INS;
              end else begin
                result_valid        <= 1'b1;
                result.slot         <= '0;
                result.status       <= ST_FULL;
                result.bytes_in_use <= bytes_used;
                busy                <= 1'b0;
                state               <= S_IDLE;
              end
            end else begin
              result_valid <= 1'b1;
              busy         <= 1'b0;
              state        <= S_IDLE;
              if (sres.found) begin
                result.slot   <= 4'(sres.slot);
                result.status <= ST_OK;
                if (req.func == F_GET_SNAP || req.func == F_GET_DELT) begin
                  recency_clock       <= clock_next;
                  result.bytes_in_use <= bytes_used;
                end else begin
                  valid[tbl][sres.slot] <= 1'b0;
                  bytes_used            <= sub_sat;
                  result.bytes_in_use   <= sub_sat;
                end
              end else begin
                result.slot         <= '0;
                result.status       <= ST_MISS;
                result.bytes_in_use <= bytes_used;
              end
            end
          end
        end
        S_INS: begin
          valid[tbl][slot_r]  <= 1'b1;
          recency_clock       <= clock_next;
          bytes_used          <= add_sat;
          result_valid        <= 1'b1;
          result.slot         <= 4'(slot_r);
          result.status       <= ST_OK;
          result.bytes_in_use <= add_sat;
          busy                <= 1'b0;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // eviction notices only come mid-request, finals close it
  a_notice_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("eviction notice outside a request");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy && state == S_IDLE)
    else $error("final result while still busy");

  a_notice_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.notice_kind == KIND_EVICT |-> result.status == ST_OK
      && !result.last)
    else $error("eviction notice with bad status");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && state == S_IDLE && cmd.func <= F_EVC_DELT |=> busy)
    else $error("accepted item did not raise busy");

  a_idle_no_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !busy)
    else $error("busy in idle state");

endmodule

/* tb/two_table_byte_budget_lru_cache_tb.sv */
`timescale 1ns / 1ps
// Testbench for the two-table byte-budget LRU cache engine: drives requests and
// capacity writes, predicts notices and answers, checks every result item.
// Depends on tbblc_pkg and two_table_byte_budget_lru_cache.
module two_table_byte_budget_lru_cache_tb;
  import tbblc_pkg::*;

  localparam logic [BYTES_W-1:0] BYTES_SAT = {BYTES_W{1'b1}};
  localparam logic [STAMP_W-1:0] STAMP_SAT = {STAMP_W{1'b1}};
  localparam logic [3:0]         CAP_ADDR  = 4'd0;
  localparam int                 WATCHDOG  = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic result_valid;
  result_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  two_table_byte_budget_lru_cache dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // shadow of the cache state
  logic [SIZE_W-1:0]  cap;
  logic               sh_valid [2][ENTRIES];
  logic [KEY_W-1:0]   sh_key   [2][ENTRIES];
  logic [SIZE_W-1:0]  sh_size  [2][ENTRIES];
  logic [STAMP_W-1:0] sh_stamp [2][ENTRIES];
  logic [BYTES_W-1:0] used;
  logic [STAMP_W-1:0] rclock;

  result_t expected_q [$];
  cmd_t    request_q [$];
  int      send_idle_pct = 0;
  int      fails = 0;
  int      quiet = 0;
  int      accepted = 0;

  task automatic push_result(logic kind, logic tbl, logic [3:0] slot,
                             logic [KEY_W-1:0] k, logic [1:0] st);
    result_t r;
    r.notice_kind = kind; r.which_table = tbl; r.slot = slot; r.entry_key = k;
    r.status = st; r.bytes_in_use = used; r.last = kind;
    expected_q.push_back(r);
  endtask

  function automatic void sub_bytes(logic [SIZE_W-1:0] v);
    used = (BYTES_W'(v) > used) ? '0 : used - BYTES_W'(v);
  endfunction

  function automatic logic [STAMP_W-1:0] next_stamp();
    logic [STAMP_W-1:0] s;
    s = rclock;
    if (rclock != STAMP_SAT) rclock = rclock + 1'b1;
    return s;
  endfunction

  function automatic bit any_valid(int t);
    for (int i = 0; i < ENTRIES; i++) if (sh_valid[t][i]) return 1;
    return 0;
  endfunction

  function automatic int slot_of(int t, logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) if (sh_valid[t][i] && sh_key[t][i] == k) return i;
    return -1;
  endfunction

  // predict the notices and answer caused by one request
  task automatic predict_request(cmd_t c);
    int t, s, bt, bs;
    bit found;
    logic [STAMP_W-1:0] best;
    logic [45:0] need;
    t = c.func[0];
    case (c.func)
      F_INS_SNAP, F_INS_DELT: begin
        forever begin
          need = {1'b0, used} + 46'(c.entry_bytes);
          if (!(need > 46'(cap) && (any_valid(0) || (t == 1 && any_valid(1))))) break;
          found = 0; bt = 0; bs = 0; best = '0;
          for (int tt = 0; tt < 2; tt++)
            for (int i = 0; i < ENTRIES; i++)
              if (sh_valid[tt][i] && (!found || sh_stamp[tt][i] < best)) begin
                found = 1; best = sh_stamp[tt][i]; bt = tt; bs = i;
              end
          sh_valid[bt][bs] = 1'b0;
          sub_bytes(sh_size[bt][bs]);
          push_result(KIND_EVICT, bt[0], bs[3:0], sh_key[bt][bs], ST_OK);
        end
        if (c.entry_bytes > cap) begin
          push_result(KIND_FINAL, t[0], 4'd0, c.key, ST_TOOBIG);
          return;
        end
        s = slot_of(t, c.key);
        if (s >= 0) sub_bytes(sh_size[t][s]);
        else begin
          for (int i = ENTRIES - 1; i >= 0; i--) if (!sh_valid[t][i]) s = i;
          if (s < 0) begin
            push_result(KIND_FINAL, t[0], 4'd0, c.key, ST_FULL);
            return;
          end
        end
        sh_valid[t][s] = 1'b1; sh_key[t][s] = c.key; sh_size[t][s] = c.entry_bytes;
        sh_stamp[t][s] = next_stamp();
        used = (BYTES_SAT - used < BYTES_W'(c.entry_bytes)) ? BYTES_SAT
               : used + BYTES_W'(c.entry_bytes);
        push_result(KIND_FINAL, t[0], s[3:0], c.key, ST_OK);
      end
      F_GET_SNAP, F_GET_DELT: begin
        s = slot_of(t, c.key);
        if (s >= 0) begin
          sh_stamp[t][s] = next_stamp();
          push_result(KIND_FINAL, t[0], s[3:0], c.key, ST_OK);
        end else push_result(KIND_FINAL, t[0], 4'd0, c.key, ST_MISS);
      end
      F_EVC_SNAP, F_EVC_DELT: begin
        s = slot_of(t, c.key);
        if (s >= 0) begin
          sh_valid[t][s] = 1'b0;
          sub_bytes(sh_size[t][s]);
          push_result(KIND_FINAL, t[0], s[3:0], c.key, ST_OK);
        end else push_result(KIND_FINAL, t[0], 4'd0, c.key, ST_MISS);
      end
      default: push_result(KIND_FINAL, 1'b0, 4'd0, c.key, ST_MISS);
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_request(cmd);
      accepted <= accepted + 1;
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd <= request_q.pop_front();
      end else begin
        start <= 1'b0;
        cmd <= '0;
      end
    end else if (!start && request_q.size() != 0
                 && $urandom_range(99) >= send_idle_pct) begin
      start <= 1'b1;
      cmd <= request_q.pop_front();
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          fails++;
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (result !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, result);
            fails++;
          end
        end
      end
      quiet <= (result_valid || (start && !busy)) ? 0 : quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_capacity(logic [SIZE_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= CAP_ADDR; pwdata <= 64'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cap = v;
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || start || busy || expected_q.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    return ($urandom_range(9) < 8) ? KEY_W'($urandom_range(11)) : k;
  endfunction

  function automatic cmd_t rand_request(int size_mode);
    cmd_t c;
    int r;
    r = $urandom_range(99);
    c.func = (r < 40) ? 3'($urandom_range(1)) : (r < 70) ? 3'(2 + $urandom_range(1))
           : (r < 95) ? 3'(4 + $urandom_range(1)) : 3'(6 + $urandom_range(1));
    c.key = pick_key();
    case (size_mode)
      0: c.entry_bytes = SIZE_W'($urandom_range(300));
      1: c.entry_bytes = SIZE_W'({$urandom, $urandom});
      default: c.entry_bytes = SIZE_W'($urandom_range(70000000));
    endcase
    return c;
  endfunction

  initial begin
    cmd_t c;
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < ENTRIES; i++) sh_valid[t][i] = 1'b0;
    used = '0; rclock = '0; cap = 40'd67108864;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: too large, fills, replace, full table, gets, evicts, bad codes
    write_capacity(40'd1000);
    request_q.push_back('{F_INS_SNAP, 64'd1, 40'd1001});
    for (int i = 0; i < 17; i++) request_q.push_back('{F_INS_DELT, 64'(100 + i), 40'd10});
    request_q.push_back('{F_INS_DELT, 64'd105, 40'd20});
    request_q.push_back('{F_GET_DELT, 64'd100, '0});
    request_q.push_back('{F_GET_SNAP, {KEY_W{1'b1}}, '0});
    request_q.push_back('{F_INS_SNAP, {KEY_W{1'b1}}, 40'd900});
    request_q.push_back('{F_EVC_DELT, 64'd101, '0});
    request_q.push_back('{F_EVC_SNAP, 64'd7, '0});
    request_q.push_back('{3'd6, 64'h5555_aaaa_5555_aaaa, {SIZE_W{1'b1}}});
    request_q.push_back('{3'd7, 64'haaaa_5555_aaaa_5555, '0});
    wait_drained();
    write_capacity({SIZE_W{1'b1}});
    request_q.push_back('{F_INS_DELT, 64'd2, {SIZE_W{1'b1}}});
    request_q.push_back('{F_INS_SNAP, 64'd3, {SIZE_W{1'b1}}});
    request_q.push_back('{F_INS_SNAP, 64'd4, 40'd0});
    wait_drained();

    // random phases: sender idle 36%, then 56%, then none in the last two, with capacity changes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 56 : 0;
      case (ph)
        0: write_capacity(40'd0);
        1: write_capacity(40'd2000);
        2: write_capacity(40'd67108864);
        default: write_capacity(40'd800);
      endcase
      for (int n = 0; n < 95; n++) begin
        c = rand_request((ph == 2) ? 2 : ($urandom_range(19) == 0) ? 1 : 0);
        request_q.push_back(c);
      end
      wait_drained();
    end

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
